// ===== rtl/c2p_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types and constants for the chunky-to-planar row converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int MAX_ROW_BYTES_DEF = 128;
    localparam int PLANES_MAX        = 8;
    localparam int WORD_W            = 64;
    localparam int APB_AW            = 3;
    localparam int APB_DW            = 32;

    localparam logic [7:0] ROW_BYTES_RST   = 8'd40;
    localparam logic [3:0] PLANE_COUNT_RST = 4'd8;

    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PLANE_COUNT = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    is_read;
        logic [2:0] plane;
        logic    last;
    } stage_t;

endpackage

// ===== rtl/c2p_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c2p_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chunky_to_planar_row_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunky_to_planar_row_converter_top
// Packs a row of 8-bit color indices into bitplane bytes held in a column
// RAM, and reads the row back out plane by plane.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_op, s_pixel_index
//  m_      | out       | m_valid / m_ready | m_status, m_plane_byte, m_row_last
//  apb     | in        | psel / penable    | paddr, pwdata, prdata
//
// One transaction per cycle while m_ does not stall; the stage register and
// the column RAM read capture on accept, the output register when it is free.
// Pixel writes build the column word in an accumulator and write it through.
// While m_ stalls, one more transaction enters the stage register, then
// s_ready drops until m_ready returns.
// Reset is synchronous; the column RAM is not cleared.
// ----------------------------------------------------------------------------
module chunky_to_planar_row_converter_top #(
    parameter int MAX_ROW_BYTES = c2p_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [c2p_pkg::APB_AW-1:0]  paddr,
    input  logic [c2p_pkg::APB_DW-1:0]  pwdata,
    output logic [c2p_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [7:0]                  s_pixel_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [7:0]                  m_plane_byte,
    output logic                        m_row_last
);
    import c2p_pkg::*;

    localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic [7:0]        row_bytes_reg;
    logic [3:0]        plane_count_reg;
    logic              cfg_wr;
    logic [31:0]       rb_full;
    logic [CW-1:0]     rb_last;
    logic [3:0]        np_eff;

    logic              err_reg, err_next;
    logic              row_full_reg, row_full_next;
    logic [2:0]        bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]     col_cnt_reg, col_cnt_next;
    logic [CW-1:0]     rd_col_reg, rd_col_next;
    logic [2:0]        rd_plane_reg, rd_plane_next;
    logic [WORD_W-1:0] acc_reg, acc_next;

    logic              accept;
    logic              out_free;
    logic              wr_en, rd_en;
    logic [WORD_W-1:0] rdata;
    stage_t            st_reg, st_next;
    logic [7:0]        byte_sel;

    logic [1:0]        m_status_reg;
    logic [7:0]        m_plane_byte_reg;
    logic              m_row_last_reg;
    logic              m_valid_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_ROW_BYTES:   prdata = {24'd0, row_bytes_reg};
            REG_PLANE_COUNT: prdata = {28'd0, plane_count_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        if (row_bytes_reg == 8'd0) begin
            rb_full = 32'd1;
        end else if ({24'd0, row_bytes_reg} > 32'(MAX_ROW_BYTES)) begin
            rb_full = 32'(MAX_ROW_BYTES);
        end else begin
            rb_full = {24'd0, row_bytes_reg};
        end
        rb_last = CW'(rb_full - 32'd1);
        if (plane_count_reg == 4'd0) begin
            np_eff = 4'd1;
        end else if (plane_count_reg > 4'(PLANES_MAX)) begin
            np_eff = 4'(PLANES_MAX);
        end else begin
            np_eff = plane_count_reg;
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !st_reg.valid || out_free;
    assign accept   = s_valid && s_ready;

    // control
    always_comb begin
        err_next       = err_reg;
        row_full_next  = row_full_reg;
        bit_cnt_next   = bit_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        rd_col_next    = rd_col_reg;
        rd_plane_next  = rd_plane_reg;
        acc_next       = (bit_cnt_reg == 3'd0) ? '0 : acc_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        st_next        = st_reg;

        for (int p = 0; p < PLANES_MAX; p++) begin
            if (s_pixel_index[p]) begin
                acc_next[p*8 + int'(3'd7 - bit_cnt_reg)] = 1'b1;
            end
        end

        if (!accept && out_free) begin
            st_next.valid = 1'b0;
        end

        if (cfg_wr) begin
            row_full_next = 1'b0;
            bit_cnt_next  = '0;
            col_cnt_next  = '0;
            rd_col_next   = '0;
            rd_plane_next = '0;
        end else if (accept) begin
            st_next.valid   = 1'b1;
            st_next.status  = ST_OK;
            st_next.is_read = 1'b0;
            st_next.plane   = rd_plane_reg;
            st_next.last    = 1'b0;
            if (err_reg) begin
                st_next.status = ST_ERR;
            end else if (s_op == OP_WRITE) begin
                if (row_full_reg) begin
                    st_next.status = ST_BUSY;
                end else if ((s_pixel_index >> np_eff) != 8'd0) begin
                    err_next       = 1'b1;
                    st_next.status = ST_ERR;
                end else begin
                    wr_en        = 1'b1;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7) begin
                        col_cnt_next = col_cnt_reg + 1'b1;
                        if (col_cnt_reg == rb_last) begin
                            row_full_next = 1'b1;
                        end
                    end
                end
            end else begin
                if (!row_full_reg) begin
                    st_next.status = ST_BUSY;
                end else begin
                    rd_en           = 1'b1;
                    st_next.is_read = 1'b1;
                    if (rd_col_reg == rb_last) begin
                        rd_col_next = '0;
                        if ({1'b0, rd_plane_reg} == np_eff - 4'd1) begin
                            st_next.last  = 1'b1;
                            row_full_next = 1'b0;
                            bit_cnt_next  = '0;
                            col_cnt_next  = '0;
                            rd_plane_next = '0;
                        end else begin
                            rd_plane_next = rd_plane_reg + 3'd1;
                        end
                    end else begin
                        rd_col_next = rd_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    c2p_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ROW_BYTES),
        .AW    (CW)
    ) u_column_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (col_cnt_reg),
        .wdata (acc_next),
        .re    (rd_en),
        .raddr (rd_col_reg),
        .rdata (rdata)
    );

    assign byte_sel = (st_reg.is_read && st_reg.status == ST_OK)
                    ? rdata[st_reg.plane*8 +: 8] : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg   <= ROW_BYTES_RST;
            plane_count_reg <= PLANE_COUNT_RST;
            err_reg         <= 1'b0;
            row_full_reg    <= 1'b0;
            bit_cnt_reg     <= '0;
            col_cnt_reg     <= '0;
            rd_col_reg      <= '0;
            rd_plane_reg    <= '0;
            st_reg          <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_ROW_BYTES:   row_bytes_reg   <= pwdata[7:0];
                    REG_PLANE_COUNT: plane_count_reg <= pwdata[3:0];
                    default:         row_bytes_reg   <= row_bytes_reg;
                endcase
            end
            err_reg      <= err_next;
            row_full_reg <= row_full_next;
            bit_cnt_reg  <= bit_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            rd_col_reg   <= rd_col_next;
            rd_plane_reg <= rd_plane_next;
            st_reg       <= st_next;
            if (out_free) begin
                m_valid_reg <= st_reg.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            acc_reg <= acc_next;
        end
        if (out_free && st_reg.valid) begin
            m_status_reg     <= st_reg.status;
            m_plane_byte_reg <= byte_sel;
            m_row_last_reg   <= st_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_plane_byte = m_plane_byte_reg;
    assign m_row_last   = m_row_last_reg;

endmodule
